FILE: hw/rtl/demand_traffic_light_controller_defines.svh
// Assertion macros used by the traffic light controller core.
`ifndef DEMAND_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH
`define DEMAND_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DTLC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DTLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dtlc_pkg.sv
// Types and constants of the demand traffic light controller.
package dtlc_pkg;

    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CARS_PER_PHASE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_LIMIT    = 1'd1;

    localparam logic [3:0] DEFAULT_GRANT = 4'd5;
    localparam logic [3:0] SECS_MAX      = 4'd15;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NS   = 2'd1,
        PH_WE   = 2'd2
    } phase_t;

    // Effective settings, zero already mapped to one.
    typedef struct packed {
        logic [3:0] cars_per_phase;
        logic [3:0] phase_limit;
    } cfg_t;

    typedef struct packed {
        logic second_tick;
        logic arrive_ew;
        logic arrive_we;
        logic arrive_sn;
        logic arrive_ns;
    } item_t;

    typedef struct packed {
        phase_t active_axis;
        logic   lamp_ew;
        logic   lamp_we;
        logic   lamp_sn;
        logic   lamp_ns;
    } result_t;

endpackage

FILE: hw/rtl/dtlc_cfg.sv
// Configuration registers of the traffic light controller.
module dtlc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [dtlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [3:0]                      cfg_data,
    output dtlc_pkg::cfg_t                  cfg
);

    logic [3:0] cars_reg;
    logic [3:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cars_reg  <= dtlc_pkg::DEFAULT_GRANT;
            limit_reg <= dtlc_pkg::DEFAULT_GRANT;
        end else if (cfg_valid) begin
            case (cfg_addr)
                dtlc_pkg::CFG_CARS_PER_PHASE: cars_reg  <= cfg_data;
                dtlc_pkg::CFG_PHASE_LIMIT:    limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero setting behaves as one.
    assign cfg.cars_per_phase = (cars_reg == 4'd0) ? 4'd1 : cars_reg;
    assign cfg.phase_limit    = (limit_reg == 4'd0) ? 4'd1 : limit_reg;

endmodule

FILE: hw/rtl/dtlc_core.sv
// Queue counters, phase state and the per-step update of the controller.
`include "demand_traffic_light_controller_defines.svh"

module dtlc_core #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  dtlc_pkg::cfg_t    cfg,
    input  dtlc_pkg::item_t   item,
    output dtlc_pkg::result_t result
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [3:0][COUNT_WIDTH-1:0] queue_reg, queue_next;
    dtlc_pkg::phase_t            phase_reg, phase_next;
    logic                        last_ns_reg, last_ns_next;
    logic [3:0]                  secs_reg, secs_next;
    logic [1:0][3:0]             serve_reg, serve_next;
    logic [1:0]                  done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_reg   <= '0;
            phase_reg   <= dtlc_pkg::PH_IDLE;
            last_ns_reg <= 1'b0;
            secs_reg    <= '0;
            serve_reg   <= '0;
            done_reg    <= '0;
        end else if (step_en) begin
            queue_reg   <= queue_next;
            phase_reg   <= phase_next;
            last_ns_reg <= last_ns_next;
            secs_reg    <= secs_next;
            serve_reg   <= serve_next;
            done_reg    <= done_next;
        end
    end

    // Next state: arrivals, then tick advance, then a possible phase start.
    always_comb begin
        logic [3:0]             arrive;
        logic [1:0]             idx;
        logic                   ns_wait;
        logic                   we_wait;
        logic [COUNT_WIDTH-1:0] q;
        logic [COUNT_WIDTH-1:0] amt;

        queue_next   = queue_reg;
        phase_next   = phase_reg;
        last_ns_next = last_ns_reg;
        secs_next    = secs_reg;
        serve_next   = serve_reg;
        done_next    = done_reg;
        arrive = {item.arrive_ew, item.arrive_we, item.arrive_sn, item.arrive_ns};
        idx     = '0;
        ns_wait = 1'b0;
        we_wait = 1'b0;
        q       = '0;
        amt     = '0;

        for (int k = 0; k < 4; k++) begin
            if (arrive[k] && queue_reg[k] != CountMax) begin
                queue_next[k] = queue_reg[k] + 1'b1;
            end
        end

        if (phase_reg != dtlc_pkg::PH_IDLE && item.second_tick) begin
            secs_next = (secs_reg != dtlc_pkg::SECS_MAX) ? secs_reg + 4'd1 : secs_reg;
            for (int k = 0; k < 2; k++) begin
                idx = {phase_reg == dtlc_pkg::PH_WE, 1'(k)};
                amt = COUNT_WIDTH'(serve_reg[k]);
                if (!done_reg[k] && secs_next >= serve_reg[k]) begin
                    queue_next[idx] = (queue_next[idx] > amt) ? queue_next[idx] - amt : '0;
                    done_next[k]    = 1'b1;
                end
            end
            // Directions finishing on the limit second still count as served.
            if ((done_next[0] && done_next[1]) || secs_next >= cfg.phase_limit) begin
                last_ns_next = (phase_reg == dtlc_pkg::PH_NS);
                phase_next   = dtlc_pkg::PH_IDLE;
            end
        end

        if (phase_next == dtlc_pkg::PH_IDLE) begin
            ns_wait = (queue_next[0] | queue_next[1]) != '0;
            we_wait = (queue_next[2] | queue_next[3]) != '0;
            if (ns_wait && we_wait) begin
                if (last_ns_next) begin
                    ns_wait = 1'b0;
                end else begin
                    we_wait = 1'b0;
                end
            end
            if (ns_wait || we_wait) begin
                phase_next = ns_wait ? dtlc_pkg::PH_NS : dtlc_pkg::PH_WE;
                secs_next  = '0;
                for (int k = 0; k < 2; k++) begin
                    idx = {we_wait, 1'(k)};
                    q   = queue_next[idx];
                    serve_next[k] = (q < COUNT_WIDTH'(cfg.cars_per_phase)) ?
                                    q[3:0] : cfg.cars_per_phase;
                    done_next[k]  = (serve_next[k] == 4'd0);
                end
            end
        end
    end

    // Outputs: lamps follow the updated phase and done flags.
    always_comb begin
        result.active_axis = phase_next;
        result.lamp_ns     = 1'b0;
        result.lamp_sn     = 1'b0;
        result.lamp_we     = 1'b0;
        result.lamp_ew     = 1'b0;
        case (phase_next)
            dtlc_pkg::PH_NS: begin
                result.lamp_ns = !done_next[0];
                result.lamp_sn = !done_next[1];
            end
            dtlc_pkg::PH_WE: begin
                result.lamp_we = !done_next[0];
                result.lamp_ew = !done_next[1];
            end
            default: ;
        endcase
    end

    `DTLC_ASSERT_NEXT(a_secs_clear_on_start,
        step_en && phase_reg == dtlc_pkg::PH_IDLE && phase_next != dtlc_pkg::PH_IDLE,
        secs_reg == 4'd0, "phase started with nonzero seconds")
    `DTLC_ASSERT_NEXT(a_queue_hold, !step_en, $stable(queue_reg),
        "queue counts moved without a transfer")
    `DTLC_ASSERT_NOW(a_active_not_done, phase_reg != dtlc_pkg::PH_IDLE,
        !(done_reg[0] && done_reg[1]), "active phase with both directions done")

endmodule

FILE: hw/rtl/demand_traffic_light_controller.sv
// Demand-actuated traffic light controller top level.
//
// s_ channel: one transfer per time step; s_tdata carries four arrival flags
// and a one-second tick. m_ channel: one result per step with four lamp bits
// and the active axis. cfg_ channel writes cars_per_phase (index 0) and
// phase_limit (index 1); cfg_ready is always high and writes are expected
// only while no step is in flight.
// A step in the input register is computed into the output register once
// that register is empty or being read. Throughput: one step per cycle
// while m_tready is high; the whole update is one pass of counter and
// compare logic between the input register and the output register.
// Reset (aresetn low, synchronous) empties both registers, clears all queue
// counters, returns to idle with all lamps dark and loads 5 into both
// settings. When m_tready is low the result holds, the input register keeps
// at most one waiting step, and s_tready stays low while that step waits.
module demand_traffic_light_controller #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] arrive_ns, [1] arrive_sn, [2] arrive_we, [3] arrive_ew,
    // [4] second_tick, [7:5] zero
    input  logic [7:0]                      s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] lamp_ns, [1] lamp_sn, [2] lamp_we, [3] lamp_ew,
    // [5:4] active_axis, [7:6] zero
    output logic [7:0]                      m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dtlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [3:0]                      cfg_data
);

    logic              in_valid_reg, in_valid_next;
    dtlc_pkg::item_t   item_reg;
    logic              out_valid_reg, out_valid_next;
    dtlc_pkg::result_t out_data_reg;
    dtlc_pkg::result_t result;
    dtlc_pkg::cfg_t    cfg;
    logic              step_en;
    logic              s_fire;

    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= dtlc_pkg::item_t'(s_tdata[4:0]);
        end
        if (step_en) begin
            out_data_reg <= result;
        end
    end

    dtlc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtlc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule
